@@ src/gok_pkg.sv @@
package gok_pkg;

    localparam int GRID_COLUMNS = 13;
    localparam int GRID_ROWS    = 4;

    localparam int COL_W = 4;
    localparam int ROW_W = 2;
    localparam int BTN_W = 10;
    localparam int CNT_W = 8;
    localparam int REG_W = 8;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    localparam logic [REG_W-1:0] DELAY_RST = 8'd14;
    localparam logic [REG_W-1:0] RATE_RST  = 8'd4;

    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_RIGHT  = 3;
    localparam int BTN_A      = 4;
    localparam int BTN_B      = 5;
    localparam int BTN_X      = 6;
    localparam int BTN_Y      = 7;
    localparam int BTN_START  = 8;
    localparam int BTN_SELECT = 9;

    localparam logic [6:0] KEY_BACKSPACE = 7'h08;
    localparam logic [6:0] KEY_SPACE     = 7'h20;
    localparam logic [6:0] KEY_NEWLINE   = 7'h0A;
    localparam logic [6:0] KEY_EOT       = 7'h04;

    localparam logic [127:0] CHAR_ROM [2][4] = '{
        '{
            "abcdefghijklm   ",
            "nopqrstuvwxyz   ",
            "0123456789._,   ",
            "()[]{}\"':=+-/   "
        },
        '{
            "ABCDEFGHIJKLM   ",
            "NOPQRSTUVWXYZ   ",
            "!@#$%^&*~`|\\;   ",
            "<>?             "
        }
    };

    typedef struct packed {
        logic btn_up;
        logic btn_down;
        logic btn_left;
        logic btn_right;
        logic btn_a;
        logic btn_b;
        logic btn_x;
        logic btn_y;
        logic btn_start;
        logic btn_select;
    } t_gok_in;

    typedef struct packed {
        logic             key_valid;
        logic [6:0]       key_code;
        logic             redraw;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic             page_sel;
    } t_gok_out;

    typedef struct packed {
        logic [BTN_W-1:0] prev_buttons;
        logic [CNT_W-1:0] hold_count;
        logic [COL_W-1:0] col_pos;
        logic [ROW_W-1:0] row_pos;
        logic             page_bit;
    } t_gok_state;

    typedef struct packed {
        logic [REG_W-1:0] rpt_wait;
        logic [REG_W-1:0] rpt_step;
    } t_gok_cfg;

    function automatic logic [6:0] gok_char(
        input logic             page,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [127:0] line;
        logic [3:0]   idx;
        line = CHAR_ROM[page][row];
        idx  = 4'd15 - col;
        return line[{idx, 3'b000} +: 7];
    endfunction

endpackage

@@ src/gok_cfg.sv @@
module gok_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gok_pkg::t_gok_cfg   o_cfg
);

    logic [gok_pkg::REG_W-1:0] r_delay;
    logic [gok_pkg::REG_W-1:0] r_rate;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= gok_pkg::DELAY_RST;
            r_rate  <= gok_pkg::RATE_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                gok_pkg::REG_DELAY: r_delay <= pwdata[gok_pkg::REG_W-1:0];
                gok_pkg::REG_RATE:  r_rate  <= pwdata[gok_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            gok_pkg::REG_DELAY: prdata = {{(32-gok_pkg::REG_W){1'b0}}, r_delay};
            gok_pkg::REG_RATE:  prdata = {{(32-gok_pkg::REG_W){1'b0}}, r_rate};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.rpt_wait = r_delay;
    assign o_cfg.rpt_step = r_rate;

endmodule

@@ src/gok_step.sv @@
module gok_step (
    input  gok_pkg::t_gok_in    i_btn,
    input  gok_pkg::t_gok_state i_state,
    input  gok_pkg::t_gok_cfg   i_cfg,
    output gok_pkg::t_gok_state o_state,
    output gok_pkg::t_gok_out   o_result
);

    logic [gok_pkg::BTN_W-1:0] pad;
    logic [gok_pkg::BTN_W-1:0] edges;
    logic [3:0]                dir;
    logic [3:0]                move;
    logic                      same_dir;
    logic [gok_pkg::CNT_W-1:0] hc_inc;
    logic [gok_pkg::CNT_W-1:0] hc_next;
    logic [gok_pkg::COL_W-1:0] col_l;
    logic [gok_pkg::COL_W-1:0] col_r;
    logic [gok_pkg::ROW_W-1:0] row_u;
    logic [gok_pkg::ROW_W-1:0] row_d;
    logic                      page_next;
    logic                      key_valid;
    logic [6:0]                key_code;
    logic                      redraw;

    assign pad = {i_btn.btn_select, i_btn.btn_start, i_btn.btn_y, i_btn.btn_x,
                  i_btn.btn_b, i_btn.btn_a, i_btn.btn_right, i_btn.btn_left,
                  i_btn.btn_down, i_btn.btn_up};
    assign edges    = pad & ~i_state.prev_buttons;
    assign dir      = pad[3:0];
    assign same_dir = (dir != 4'd0) && (dir == i_state.prev_buttons[3:0]);
    assign hc_inc   = (i_state.hold_count == gok_pkg::CNT_MAX) ? gok_pkg::CNT_MAX
                                                              : i_state.hold_count + 1'b1;

    // autorepeat counter; moves on new presses and on repeat
    always_comb begin
        move    = edges[3:0];
        hc_next = '0;
        if (same_dir) begin
            hc_next = hc_inc;
            if (hc_inc >= i_cfg.rpt_wait) begin
                hc_next = (hc_inc > i_cfg.rpt_step) ? hc_inc - i_cfg.rpt_step : '0;
                move    = dir;
            end
        end
    end

    // left then right, up then down
    always_comb begin
        col_l = i_state.col_pos;
        if (move[gok_pkg::BTN_LEFT]) begin
            col_l = (i_state.col_pos == '0) ? gok_pkg::COL_LAST : i_state.col_pos - 1'b1;
        end
        col_r = col_l;
        if (move[gok_pkg::BTN_RIGHT]) begin
            col_r = (col_l >= gok_pkg::COL_LAST) ? '0 : col_l + 1'b1;
        end
        row_u = i_state.row_pos;
        if (move[gok_pkg::BTN_UP]) begin
            row_u = (i_state.row_pos == '0) ? gok_pkg::ROW_LAST : i_state.row_pos - 1'b1;
        end
        row_d = row_u;
        if (move[gok_pkg::BTN_DOWN]) begin
            row_d = (row_u >= gok_pkg::ROW_LAST) ? '0 : row_u + 1'b1;
        end
    end

    always_comb begin
        key_valid = 1'b0;
        key_code  = '0;
        redraw    = 1'b0;
        page_next = i_state.page_bit;
        if (move != 4'd0) begin
            redraw = 1'b1;
        end else if (edges[gok_pkg::BTN_Y]) begin
            page_next = ~i_state.page_bit;
            redraw    = 1'b1;
        end else if (edges[gok_pkg::BTN_A]) begin
            key_valid = 1'b1;
            key_code  = gok_pkg::gok_char(i_state.page_bit, i_state.row_pos, i_state.col_pos);
        end else if (edges[gok_pkg::BTN_B]) begin
            key_valid = 1'b1;
            key_code  = gok_pkg::KEY_BACKSPACE;
        end else if (edges[gok_pkg::BTN_X]) begin
            key_valid = 1'b1;
            key_code  = gok_pkg::KEY_SPACE;
        end else if (edges[gok_pkg::BTN_START]) begin
            key_valid = 1'b1;
            key_code  = gok_pkg::KEY_NEWLINE;
        end else if (edges[gok_pkg::BTN_SELECT]) begin
            key_valid = 1'b1;
            key_code  = gok_pkg::KEY_EOT;
        end
    end

    assign o_state.prev_buttons = pad;
    assign o_state.hold_count   = hc_next;
    assign o_state.col_pos      = col_r;
    assign o_state.row_pos      = row_d;
    assign o_state.page_bit     = page_next;

    assign o_result.key_valid  = key_valid;
    assign o_result.key_code   = key_code;
    assign o_result.redraw     = redraw;
    assign o_result.cursor_col = col_r;
    assign o_result.cursor_row = row_d;
    assign o_result.page_sel   = page_next;

endmodule

@@ src/gamepad_onscreen_keyboard_top.sv @@
// An accepted item goes through the input register, then the result register, which
// drives o_out_valid; both registers hold while the output is stalled.
// Throughput: one item per cycle unless the output stalls; the cursor/repeat update
// is a single pass of logic between the input register and the result register.
// Reset (synchronous, active low): pipeline empty, cursor, page, repeat count
// and previous sample cleared; repeat wait 14 frames, repeat step 4 frames.
module gamepad_onscreen_keyboard_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gok_pkg::t_gok_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gok_pkg::t_gok_out   o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                r_in_valid;
    gok_pkg::t_gok_in    r_in;
    logic                r_out_valid;
    gok_pkg::t_gok_out   r_out;
    gok_pkg::t_gok_state r_state;
    gok_pkg::t_gok_state n_state;
    gok_pkg::t_gok_out   n_out;
    gok_pkg::t_gok_cfg   cfg;
    logic                out_adv;

    gok_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gok_step u_step (
        .i_btn    (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (out_adv && r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_col <= gok_pkg::COL_LAST))
        else $error("cursor column out of range");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.key_valid) |-> (o_out_data.key_code == 7'd0))
        else $error("key code without key valid");

    a_key_or_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.key_valid && o_out_data.redraw))
        else $error("key and redraw in the same item");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_state))
        else $error("state changed without an item");

endmodule

@@ tb/sv/gamepad_onscreen_keyboard_top_tb.sv @@
`timescale 1ns / 1ps

module gamepad_onscreen_keyboard_top_tb;

    localparam int LIMIT           = 400000;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int NUM_PHASES      = 8;
    localparam int PAD_W           = gok_pkg::BTN_W;
    localparam int CFG_W           = gok_pkg::REG_W;

    localparam logic [2:0] ADDR_DELAY = {gok_pkg::REG_DELAY, 2'b00};
    localparam logic [2:0] ADDR_RATE  = {gok_pkg::REG_RATE, 2'b00};

    localparam int PH_DELAY [NUM_PHASES] = '{14, 1, 255, 3, 255, 1, 0, 14};
    localparam int PH_RATE  [NUM_PHASES] = '{4, 1, 255, 7, 1, 255, 0, 4};
    localparam int PH_IDLE  [NUM_PHASES] = '{0, 58, 0, 34, 0, 0, 34, 0};
    localparam int PH_STALL [NUM_PHASES] = '{0, 0, 58, 34, 0, 58, 34, 0};

    localparam int DIRECTED_ORDER [10] = '{gok_pkg::BTN_UP, gok_pkg::BTN_DOWN,
                                           gok_pkg::BTN_LEFT, gok_pkg::BTN_RIGHT,
                                           gok_pkg::BTN_Y, gok_pkg::BTN_A, gok_pkg::BTN_B,
                                           gok_pkg::BTN_X, gok_pkg::BTN_START,
                                           gok_pkg::BTN_SELECT};

    class osk_checker;
        gok_pkg::t_gok_out          frames_due[$];
        string                      glyphs[2][4];
        logic [gok_pkg::BTN_W-1:0]  last_pad;
        logic [gok_pkg::CNT_W-1:0]  hold;
        logic [gok_pkg::COL_W-1:0]  col;
        logic [gok_pkg::ROW_W-1:0]  row;
        logic                       page;
        logic [gok_pkg::REG_W-1:0]  delay;
        logic [gok_pkg::REG_W-1:0]  rate;
        int                         errors;
        int                         frames;
        int                         typed;
        int                         redraws;

        function new();
            string s;
            glyphs[0][0] = "abcdefghijklm   ";
            glyphs[0][1] = "nopqrstuvwxyz   ";
            glyphs[0][2] = "0123456789._,   ";
            glyphs[0][3] = "()[]{}\"':=+-/   ";
            glyphs[1][0] = "ABCDEFGHIJKLM   ";
            glyphs[1][1] = "NOPQRSTUVWXYZ   ";
            s = "!@#$%^&*~.|\\;   ";
            s[9] = 8'h60;
            glyphs[1][2] = s;
            glyphs[1][3] = "<>?             ";
            last_pad = '0;
            hold     = '0;
            col      = '0;
            row      = '0;
            page     = 1'b0;
            delay    = gok_pkg::DELAY_RST;
            rate     = gok_pkg::RATE_RST;
            errors   = 0;
            frames   = 0;
            typed    = 0;
            redraws  = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [gok_pkg::REG_W-1:0] val);
            if (addr == ADDR_DELAY) begin
                delay = val;
            end else if (addr == ADDR_RATE) begin
                rate = val;
            end
        endfunction

        function void take_pad(gok_pkg::t_gok_in p);
            logic [gok_pkg::BTN_W-1:0] pad;
            logic [gok_pkg::BTN_W-1:0] rise;
            logic [3:0]                dirs;
            logic [3:0]                move;
            gok_pkg::t_gok_out         f;
            string                     line;
            byte                       ch;
            pad                      = '0;
            pad[gok_pkg::BTN_UP]     = p.btn_up;
            pad[gok_pkg::BTN_DOWN]   = p.btn_down;
            pad[gok_pkg::BTN_LEFT]   = p.btn_left;
            pad[gok_pkg::BTN_RIGHT]  = p.btn_right;
            pad[gok_pkg::BTN_A]      = p.btn_a;
            pad[gok_pkg::BTN_B]      = p.btn_b;
            pad[gok_pkg::BTN_X]      = p.btn_x;
            pad[gok_pkg::BTN_Y]      = p.btn_y;
            pad[gok_pkg::BTN_START]  = p.btn_start;
            pad[gok_pkg::BTN_SELECT] = p.btn_select;
            rise = pad & ~last_pad;
            dirs = pad[gok_pkg::BTN_RIGHT:gok_pkg::BTN_UP];
            move = rise[gok_pkg::BTN_RIGHT:gok_pkg::BTN_UP];
            f    = '0;

            if (dirs != 0 && dirs == last_pad[gok_pkg::BTN_RIGHT:gok_pkg::BTN_UP]) begin
                if (hold != 8'hFF) begin
                    hold = hold + 1'b1;
                end
                if (hold >= delay) begin
                    hold = (hold > rate) ? hold - rate : '0;
                    move = dirs;
                end
            end else begin
                hold = '0;
            end
            last_pad = pad;

            if (move != 0) begin
                if (move[gok_pkg::BTN_LEFT]) begin
                    col = (col == 0) ? gok_pkg::COL_LAST : col - 1'b1;
                end
                if (move[gok_pkg::BTN_RIGHT]) begin
                    col = (col >= gok_pkg::GRID_COLUMNS - 1) ? '0 : col + 1'b1;
                end
                if (move[gok_pkg::BTN_UP]) begin
                    row = (row == 0) ? gok_pkg::ROW_LAST : row - 1'b1;
                end
                if (move[gok_pkg::BTN_DOWN]) begin
                    row = (row >= gok_pkg::GRID_ROWS - 1) ? '0 : row + 1'b1;
                end
                f.redraw = 1'b1;
            end else if (rise[gok_pkg::BTN_Y]) begin
                page     = ~page;
                f.redraw = 1'b1;
            end else if (rise[gok_pkg::BTN_A]) begin
                line        = glyphs[page][row];
                ch          = (col < 16) ? line[col] : 8'h20;
                f.key_valid = 1'b1;
                f.key_code  = ch[6:0];
            end else if (rise[gok_pkg::BTN_B]) begin
                f.key_valid = 1'b1;
                f.key_code  = gok_pkg::KEY_BACKSPACE;
            end else if (rise[gok_pkg::BTN_X]) begin
                f.key_valid = 1'b1;
                f.key_code  = gok_pkg::KEY_SPACE;
            end else if (rise[gok_pkg::BTN_START]) begin
                f.key_valid = 1'b1;
                f.key_code  = gok_pkg::KEY_NEWLINE;
            end else if (rise[gok_pkg::BTN_SELECT]) begin
                f.key_valid = 1'b1;
                f.key_code  = gok_pkg::KEY_EOT;
            end
            f.cursor_col = col;
            f.cursor_row = row;
            f.page_sel   = page;
            frames_due.push_back(f);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_frame(gok_pkg::t_gok_out got);
            gok_pkg::t_gok_out want;
            if (frames_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected item %h, nothing pending", $time, got);
                return;
            end
            want = frames_due.pop_front();
            compare("key_valid", 8'(want.key_valid), 8'(got.key_valid));
            compare("key_code", 8'(want.key_code), 8'(got.key_code));
            compare("redraw", 8'(want.redraw), 8'(got.redraw));
            compare("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
            compare("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
            compare("page_sel", 8'(want.page_sel), 8'(got.page_sel));
            frames++;
            if (want.key_valid) begin
                typed++;
            end
            if (want.redraw) begin
                redraws++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    gok_pkg::t_gok_in  i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    gok_pkg::t_gok_out o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          sent_count = 0;
    int          cycles     = 0;
    osk_checker  sb;

    gamepad_onscreen_keyboard_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.take_pad(i_in_data);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_frame(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [PAD_W-1:0] btn(int idx);
        return PAD_W'(1) << idx;
    endfunction

    task automatic send_frame(input logic [PAD_W-1:0] pad);
        gok_pkg::t_gok_in d;
        d.btn_up     = pad[gok_pkg::BTN_UP];
        d.btn_down   = pad[gok_pkg::BTN_DOWN];
        d.btn_left   = pad[gok_pkg::BTN_LEFT];
        d.btn_right  = pad[gok_pkg::BTN_RIGHT];
        d.btn_a      = pad[gok_pkg::BTN_A];
        d.btn_b      = pad[gok_pkg::BTN_B];
        d.btn_x      = pad[gok_pkg::BTN_X];
        d.btn_y      = pad[gok_pkg::BTN_Y];
        d.btn_start  = pad[gok_pkg::BTN_START];
        d.btn_select = pad[gok_pkg::BTN_SELECT];
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(addr, val);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic random_frames(input int budget);
        int         stop;
        int         kind;
        int         len;
        int         cap;
        logic [3:0] dirs;
        stop = sent_count + budget;
        while (sent_count < stop) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                dirs = 4'($urandom_range(1, 15));
                cap  = int'(sb.delay) + 2 * int'(sb.rate) + 4;
                if (cap > 300) begin
                    cap = 300;
                end
                len = $urandom_range(1, cap);
                if (len > stop - sent_count) begin
                    len = stop - sent_count;
                end
                repeat (len) begin
                    send_frame({($urandom_range(99) < 30) ? 6'($urandom) : 6'd0, dirs});
                end
                if ($urandom_range(1) == 1) begin
                    send_frame('0);
                end
            end else if (kind < 75) begin
                send_frame(btn($urandom_range(gok_pkg::BTN_SELECT, gok_pkg::BTN_A)));
            end else if (kind < 90) begin
                send_frame(PAD_W'($urandom));
            end else begin
                send_frame('0);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] r;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                if (PH_DELAY[ph] == 0) begin
                    d = CFG_W'($urandom_range(1, 255));
                    r = CFG_W'($urandom_range(1, 255));
                end else begin
                    d = CFG_W'(PH_DELAY[ph]);
                    r = CFG_W'(PH_RATE[ph]);
                end
                write_reg(ADDR_DELAY, d);
                write_reg(ADDR_RATE, r);
            end
            idle_pct  = PH_IDLE[ph];
            stall_pct = PH_STALL[ph];
            if (ph == 0) begin
                foreach (DIRECTED_ORDER[i]) begin
                    send_frame(btn(DIRECTED_ORDER[i]));
                end
                send_frame(btn(gok_pkg::BTN_LEFT) | btn(gok_pkg::BTN_RIGHT));
                send_frame('0);
                send_frame(btn(gok_pkg::BTN_UP) | btn(gok_pkg::BTN_DOWN));
                send_frame('1);
                send_frame('0);
                send_frame(btn(gok_pkg::BTN_A) | btn(gok_pkg::BTN_B));
                send_frame('0);
                send_frame(btn(gok_pkg::BTN_Y) | btn(gok_pkg::BTN_A));
                send_frame('0);
            end
            random_frames(ITEMS_PER_PHASE);
        end

        drain();
        if (sb.frames_due.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, sb.frames_due.size());
        end
        $display("Checked %0d frames: %0d keys typed, %0d cursor or page redraws,",
                 sb.frames, sb.typed, sb.redraws);
        $display("across %0d repeat delay/rate settings with sender and receiver throttling.",
                 NUM_PHASES);
        if (sb.errors == 0 && sb.frames_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
